// File: hdl/crchk_pkg.sv
// Shared types, widths and modular arithmetic helpers for the composition
// residue checker. No dependencies; every other file refers to it by scope.
package crchk_pkg;

	localparam int MOD_WIDTH   = 62;
	localparam int PART_WIDTH  = 8;
	localparam int COUNT_WIDTH = 48;
	localparam int RED_CNT_W   = $clog2(MOD_WIDTH + 1);

	typedef logic [MOD_WIDTH-1:0]   mod_t;
	typedef logic [PART_WIDTH-1:0]  part_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [RED_CNT_W-1:0]   red_cnt_t;

	// Controller states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REDUCE = 4'b0010,
		ST_STEP   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;       // capture an accepted part
		logic red_start;  // begin re-reducing state against a new modulus
		logic red_step;   // one bit of the reduction
		logic step;       // one step of the Horner / doubling work
		logic finish;     // publish the result and restart the composition
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic dirty;      // state needs reducing: modulus written, or restart under modulus one
		logic red_last;   // this reduction bit is the final one
		logic step_done;  // this step cycle completes the part
		logic last;       // the part in work closes its composition
		logic out_free;   // the result register can take a new result
	} stat_t;

	// (a + b) mod m for a, b < m
	function automatic mod_t mod_add(mod_t a, mod_t b, mod_t m);
		logic [MOD_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[MOD_WIDTH-1:0];
	endfunction

	// (2r + bit) mod m for r < m: one bit of a restoring reduction
	function automatic mod_t red_bit(mod_t r, logic b, mod_t m);
		logic [MOD_WIDTH:0] s;
		s = {r, b};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[MOD_WIDTH-1:0];
	endfunction

	function automatic count_t sat_inc(count_t c);
		return (c == '1) ? c : c + count_t'(1);
	endfunction

endpackage

// File: hdl/crchk_if.sv
// Valid/ready channel interfaces for parts in and results out.
// Depends on crchk_pkg for field widths.
interface crchk_in_if;
	logic                   valid;
	logic                   ready;
	crchk_pkg::part_t       part_value;
	logic                   last_part;

	modport source (output valid, output part_value, output last_part, input ready);
	modport sink   (input valid, input part_value, input last_part, output ready);
endinterface

interface crchk_out_if;
	logic                   valid;
	logic                   ready;
	crchk_pkg::mod_t        residue;
	logic                   is_zero;
	logic                   is_trivial;
	crchk_pkg::count_t      compositions_seen;
	crchk_pkg::count_t      zeros_seen;
	crchk_pkg::count_t      nontrivial_seen;

	modport source (output valid, output residue, output is_zero, output is_trivial,
		output compositions_seen, output zeros_seen, output nontrivial_seen, input ready);
	modport sink   (input valid, input residue, input is_zero, input is_trivial,
		input compositions_seen, input zeros_seen, input nontrivial_seen, output ready);
endinterface

// File: hdl/crchk_datapath.sv
// Datapath: modulus register, Horner accumulator, power doubler, bit-serial
// re-reduction, saturating totals and the result register. Uses crchk_pkg.
module crchk_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  crchk_pkg::mod_t      cfg_wdata,
	input  crchk_pkg::part_t     part_value,
	input  logic                 last_part,
	input  logic                 out_ready,
	input  crchk_pkg::cmd_t      cmd,
	output crchk_pkg::stat_t     stat,
	output logic                 out_valid,
	output crchk_pkg::mod_t      residue,
	output logic                 is_zero,
	output logic                 is_trivial,
	output crchk_pkg::count_t    compositions_seen,
	output crchk_pkg::count_t    zeros_seen,
	output crchk_pkg::count_t    nontrivial_seen
);

	localparam logic [1:0] PH_ADD_POW = 2'd0;
	localparam logic [1:0] PH_ADD_ACC = 2'd1;
	localparam logic [1:0] PH_WRITE   = 2'd2;
	localparam logic [1:0] PH_DONE    = 2'd3;

	crchk_pkg::mod_t     modulus_q, m_eff;
	logic                dirty_q;
	crchk_pkg::mod_t     acc_q, pow_q, sum_q;
	crchk_pkg::mod_t     sh_acc_q, sh_pow_q;
	crchk_pkg::red_cnt_t red_cnt_q;
	crchk_pkg::part_t    part_cnt_q;
	logic [1:0]          phase_q;
	logic                last_q, all_two_q, out_valid_q;
	crchk_pkg::count_t   comp_total_q, zero_total_q, nontriv_total_q;
	crchk_pkg::count_t   comp_next, zero_next, nontriv_next;
	logic                acc_zero;

	// A zero modulus behaves as one
	assign m_eff    = (modulus_q == '0) ? crchk_pkg::mod_t'(1) : modulus_q;
	assign acc_zero = (acc_q == '0);

	assign comp_next    = crchk_pkg::sat_inc(comp_total_q);
	assign zero_next    = acc_zero ? crchk_pkg::sat_inc(zero_total_q) : zero_total_q;
	assign nontriv_next = (acc_zero && !all_two_q) ? crchk_pkg::sat_inc(nontriv_total_q)
		: nontriv_total_q;

	assign stat.dirty     = dirty_q;
	assign stat.red_last  = (red_cnt_q == crchk_pkg::red_cnt_t'(1));
	assign stat.step_done = (phase_q == PH_WRITE || phase_q == PH_DONE) &&
		(part_cnt_q <= crchk_pkg::part_t'(1));
	assign stat.last      = last_q;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q       <= crchk_pkg::mod_t'(1);
			// power of one is not reduced against the reset modulus of one
			dirty_q         <= 1'b1;
			acc_q           <= '0;
			pow_q           <= crchk_pkg::mod_t'(1);
			all_two_q       <= 1'b1;
			phase_q         <= PH_DONE;
			part_cnt_q      <= '0;
			red_cnt_q       <= '0;
			last_q          <= 1'b0;
			out_valid_q     <= 1'b0;
			comp_total_q    <= '0;
			zero_total_q    <= '0;
			nontriv_total_q <= '0;
		end else begin
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
				dirty_q   <= 1'b1;
			end else if (cmd.red_start) begin
				dirty_q   <= 1'b0;
			end else if (cmd.finish && m_eff == crchk_pkg::mod_t'(1)) begin
				// restart power of one needs reducing before it is used
				dirty_q   <= 1'b1;
			end

			if (cmd.load) begin
				part_cnt_q <= part_value;
				last_q     <= last_part;
				phase_q    <= PH_ADD_POW;
				all_two_q  <= all_two_q & (part_value == crchk_pkg::part_t'(2));
			end

			if (cmd.red_start) begin
				acc_q     <= '0;
				pow_q     <= '0;
				red_cnt_q <= crchk_pkg::red_cnt_t'(crchk_pkg::MOD_WIDTH);
			end else if (cmd.red_step) begin
				acc_q     <= crchk_pkg::red_bit(acc_q, sh_acc_q[crchk_pkg::MOD_WIDTH-1], m_eff);
				pow_q     <= crchk_pkg::red_bit(pow_q, sh_pow_q[crchk_pkg::MOD_WIDTH-1], m_eff);
				red_cnt_q <= red_cnt_q - crchk_pkg::red_cnt_t'(1);
			end else if (cmd.step) begin
				// acc becomes acc + p + acc + acc while p doubles alongside
				if (phase_q == PH_WRITE) begin
					acc_q <= crchk_pkg::mod_add(sum_q, acc_q, m_eff);
				end
				if (phase_q != PH_DONE) begin
					phase_q <= phase_q + 2'd1;
				end
				if (part_cnt_q != '0) begin
					pow_q      <= crchk_pkg::mod_add(pow_q, pow_q, m_eff);
					part_cnt_q <= part_cnt_q - crchk_pkg::part_t'(1);
				end
			end else if (cmd.finish) begin
				acc_q           <= '0;
				pow_q           <= crchk_pkg::mod_t'(1);
				all_two_q       <= 1'b1;
				comp_total_q    <= comp_next;
				zero_total_q    <= zero_next;
				nontriv_total_q <= nontriv_next;
			end

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.red_start) begin
			sh_acc_q <= acc_q;
			sh_pow_q <= pow_q;
		end else if (cmd.red_step) begin
			sh_acc_q <= {sh_acc_q[crchk_pkg::MOD_WIDTH-2:0], 1'b0};
			sh_pow_q <= {sh_pow_q[crchk_pkg::MOD_WIDTH-2:0], 1'b0};
		end

		if (cmd.step) begin
			case (phase_q)
				PH_ADD_POW: sum_q <= crchk_pkg::mod_add(acc_q, pow_q, m_eff);
				PH_ADD_ACC: sum_q <= crchk_pkg::mod_add(sum_q, acc_q, m_eff);
				default:    sum_q <= sum_q;
			endcase
		end

		if (cmd.finish) begin
			residue           <= acc_q;
			is_zero           <= acc_zero;
			is_trivial        <= all_two_q;
			compositions_seen <= comp_next;
			zeros_seen        <= zero_next;
			nontrivial_seen   <= nontriv_next;
		end
	end

endmodule

// File: hdl/crchk_ctrl.sv
// Controller state machine: sequences accept, re-reduction, the per-part
// work and result hand-off. Uses crchk_pkg for states, commands and status.
module crchk_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  crchk_pkg::stat_t  stat,
	output crchk_pkg::cmd_t   cmd
);

	crchk_pkg::state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			crchk_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load      = 1'b1;
					cmd.red_start = stat.dirty;
					state_d       = stat.dirty ? crchk_pkg::ST_REDUCE : crchk_pkg::ST_STEP;
				end
			end
			crchk_pkg::ST_REDUCE: begin
				cmd.red_step = 1'b1;
				if (stat.red_last) begin
					state_d = crchk_pkg::ST_STEP;
				end
			end
			crchk_pkg::ST_STEP: begin
				cmd.step = 1'b1;
				if (stat.step_done) begin
					state_d = stat.last ? crchk_pkg::ST_FINISH : crchk_pkg::ST_IDLE;
				end
			end
			crchk_pkg::ST_FINISH: begin
				// hold until the result register frees up
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = crchk_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = crchk_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crchk_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/composition_residue_checker_core.sv
// Composition residue checker: each part transfer is accepted, then worked
// through the three modular adds of the Horner step running beside one
// modular doubling of the power per unit of the part. A part that closes its
// composition then loads the result register, once any earlier result in
// that register has been taken. The first part after a modulus write, and the
// first part of each composition while the modulus is zero or one (reset
// included), has the stored accumulator and power re-reduced first against
// the modulus, one bit per cycle over MOD_WIDTH bits. Results stay in a
// register, so a new part can be taken while the previous result is still
// waiting. A zero modulus acts as 1.
// Depends on crchk_pkg, crchk_if, crchk_ctrl and crchk_datapath.
module composition_residue_checker_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  crchk_pkg::mod_t      cfg_wdata,
	crchk_in_if.sink             item_ch,
	crchk_out_if.source          result_ch
);

	crchk_pkg::cmd_t  cmd;
	crchk_pkg::stat_t stat;

	crchk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_ch.valid),
		.in_ready (item_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	crchk_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.part_value        (item_ch.part_value),
		.last_part         (item_ch.last_part),
		.out_ready         (result_ch.ready),
		.cmd               (cmd),
		.stat              (stat),
		.out_valid         (result_ch.valid),
		.residue           (result_ch.residue),
		.is_zero           (result_ch.is_zero),
		.is_trivial        (result_ch.is_trivial),
		.compositions_seen (result_ch.compositions_seen),
		.zeros_seen        (result_ch.zeros_seen),
		.nontrivial_seen   (result_ch.nontrivial_seen)
	);

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for composition_residue_checker_core: drives composition parts,
// predicts every residue and count by Horner's rule, and compares each result transfer.
// Depends on crchk_pkg, crchk_if and the RTL of the core.
module tb_top;

	localparam int SETTLE_CYCLES = 400;
	localparam int RANDOM_PARTS  = 900;

	typedef struct packed {
		crchk_pkg::mod_t   residue;
		logic              is_zero;
		logic              is_trivial;
		crchk_pkg::count_t compositions_seen;
		crchk_pkg::count_t zeros_seen;
		crchk_pkg::count_t nontrivial_seen;
	} composition_result_t;

	class composition_scoreboard;
		crchk_pkg::mod_t     modulus;
		logic [63:0]         acc_q;
		logic [63:0]         pow_q;
		bit                  every_two;
		crchk_pkg::count_t   comp_total;
		crchk_pkg::count_t   zero_total;
		crchk_pkg::count_t   nontriv_total;
		composition_result_t expected_residues[$];
		int                  mismatches;

		function new();
			modulus       = crchk_pkg::mod_t'(1);
			acc_q         = 64'd0;
			pow_q         = 64'd1;
			every_two     = 1'b1;
			comp_total    = '0;
			zero_total    = '0;
			nontriv_total = '0;
			mismatches    = 0;
		endfunction

		function void set_modulus(crchk_pkg::mod_t v);
			modulus = v;
		endfunction

		function crchk_pkg::count_t bump(crchk_pkg::count_t c);
			return (c == '1) ? c : c + crchk_pkg::count_t'(1);
		endfunction

		// Advance the Horner sum by one accepted part; queue a result on the closing part
		function void note_part(crchk_pkg::part_t pv, logic lp);
			logic [63:0]         m;
			logic [63:0]         acc;
			logic [63:0]         p;
			composition_result_t r;
			m   = (modulus == '0) ? 64'd1 : {2'b00, modulus};
			acc = acc_q % m;
			p   = pow_q % m;
			acc = (64'd3 * acc + p) % m;
			for (int i = 0; i < int'(pv); i++) begin
				p = p << 1;
				if (p >= m) begin
					p = p - m;
				end
			end
			acc_q = acc;
			pow_q = p;
			if (pv != crchk_pkg::part_t'(2)) begin
				every_two = 1'b0;
			end
			if (lp) begin
				comp_total = bump(comp_total);
				if (acc == 64'd0) begin
					zero_total = bump(zero_total);
					if (!every_two) begin
						nontriv_total = bump(nontriv_total);
					end
				end
				r.residue           = crchk_pkg::mod_t'(acc);
				r.is_zero           = (acc == 64'd0);
				r.is_trivial        = every_two;
				r.compositions_seen = comp_total;
				r.zeros_seen        = zero_total;
				r.nontrivial_seen   = nontriv_total;
				expected_residues.push_back(r);
				acc_q     = 64'd0;
				pow_q     = 64'd1;
				every_two = 1'b1;
			end
		endfunction

		function void compare_field(string name, logic [63:0] e, logic [63:0] g);
			if (e !== g) begin
				$display("%0t: %s expected %0h, actual %0h", $time, name, e, g);
				mismatches++;
			end
		endfunction

		function void check_result(composition_result_t got);
			composition_result_t e;
			if (expected_residues.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, actual residue %0h",
					$time, got.residue);
				mismatches++;
				return;
			end
			e = expected_residues.pop_front();
			compare_field("residue", e.residue, got.residue);
			compare_field("is_zero", e.is_zero, got.is_zero);
			compare_field("is_trivial", e.is_trivial, got.is_trivial);
			compare_field("compositions_seen", e.compositions_seen, got.compositions_seen);
			compare_field("zeros_seen", e.zeros_seen, got.zeros_seen);
			compare_field("nontrivial_seen", e.nontrivial_seen, got.nontrivial_seen);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	crchk_pkg::mod_t   cfg_wdata;
	bit                idle_on;
	int                twos_len;
	int                parts_sent;

	composition_scoreboard sb;

	crchk_in_if  item_ch();
	crchk_out_if result_ch();

	composition_residue_checker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item_ch   (item_ch),
		.result_ch (result_ch)
	);

	always #5 clk = ~clk;

	// Check the result transfer seen at this edge, then pick the next ready
	always @(posedge clk) begin
		composition_result_t got;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got.residue           = result_ch.residue;
				got.is_zero           = result_ch.is_zero;
				got.is_trivial        = result_ch.is_trivial;
				got.compositions_seen = result_ch.compositions_seen;
				got.zeros_seen        = result_ch.zeros_seen;
				got.nontrivial_seen   = result_ch.nontrivial_seen;
				sb.check_result(got);
			end
			result_ch.ready <= !idle_on || ($urandom_range(99) >= 33);
		end else begin
			result_ch.ready <= 1'b0;
		end
	end

	function automatic logic [63:0] pow3(int y);
		logic [63:0] r;
		r = 64'd1;
		for (int i = 0; i < y; i++) begin
			r = r * 64'd3;
		end
		return r;
	endfunction

	// Moduli of the form 2^x - 3^y, or small, zero, full-scale and random ones
	function automatic crchk_pkg::mod_t pick_modulus();
		int          x;
		int          y;
		logic [63:0] v;
		twos_len = $urandom_range(1, 6);
		case ($urandom_range(5))
			0: begin
				y        = $urandom_range(1, 15);
				v        = (64'd1 << (2 * y)) - pow3(y);
				twos_len = y;
			end
			1: begin
				y = $urandom_range(1, 38);
				x = 1;
				while ((64'd1 << x) <= pow3(y)) begin
					x++;
				end
				x = $urandom_range(x, 61);
				v = (64'd1 << x) - pow3(y);
			end
			2: v = $urandom_range(1, 31);
			3: v = 64'd0;
			4: v = '1;
			default: v = {$urandom, $urandom};
		endcase
		return crchk_pkg::mod_t'(v);
	endfunction

	function automatic crchk_pkg::part_t pick_part();
		int r;
		r = $urandom_range(99);
		if (r < 62) begin
			return crchk_pkg::part_t'($urandom_range(1, 4));
		end else if (r < 80) begin
			return crchk_pkg::part_t'($urandom_range(5, 40));
		end else if (r < 95) begin
			return crchk_pkg::part_t'($urandom_range(0, 255));
		end
		return crchk_pkg::part_t'(0);
	endfunction

	task automatic send_part(input crchk_pkg::part_t pv, input logic lp);
		if (idle_on && $urandom_range(99) < 33) begin
			item_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 33);
		end
		item_ch.valid      <= 1'b1;
		item_ch.part_value <= pv;
		item_ch.last_part  <= lp;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_part(pv, lp);
		parts_sent++;
	endtask

	task automatic send_parts(input crchk_pkg::part_t parts[$], input bit closes);
		foreach (parts[i]) begin
			send_part(parts[i], closes && (i == parts.size() - 1));
		end
	endtask

	// Drop valid, wait out every expected result, then give any part still in work time to end
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (sb.expected_residues.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_modulus(input crchk_pkg::mod_t v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_modulus(v);
	endtask

	initial begin
		crchk_pkg::part_t q[$];
		int               phase;
		int               start;
		int               len;
		sb                 = new();
		idle_on            = 1'b1;
		twos_len           = 1;
		parts_sent         = 0;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		item_ch.valid      <= 1'b0;
		item_ch.part_value <= '0;
		item_ch.last_part  <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset modulus of one: everything reduces to zero, part zero included
		send_parts('{2}, 1'b1);
		send_parts('{3, 0}, 1'b1);
		settle();
		write_modulus(crchk_pkg::mod_t'(7));
		send_parts('{2, 2}, 1'b1);
		send_parts('{255, 1, 128}, 1'b1);
		send_parts('{1}, 1'b1);
		settle();
		write_modulus('0);
		send_parts('{5, 2}, 1'b1);
		settle();
		write_modulus('1);
		send_parts('{255, 255, 255}, 1'b1);
		send_parts('{0}, 1'b1);
		// Change the modulus between the parts of one composition
		send_parts('{4, 9}, 1'b0);
		settle();
		write_modulus(crchk_pkg::mod_t'(13));
		send_parts('{2}, 1'b1);
		settle();
		write_modulus(crchk_pkg::mod_t'((64'd1 << 61) - pow3(38)));
		send_parts('{170, 85}, 1'b1);

		phase = 0;
		start = parts_sent;
		while (parts_sent - start < RANDOM_PARTS) begin
			settle();
			write_modulus(pick_modulus());
			idle_on = !(phase >= 4 && phase <= 7);
			repeat ($urandom_range(3, 15)) begin
				q.delete();
				if ($urandom_range(99) < 15) begin
					len = $urandom_range(1) ? twos_len : $urandom_range(1, 6);
					repeat (len) q.push_back(crchk_pkg::part_t'(2));
				end else begin
					repeat ($urandom_range(1, 6)) q.push_back(pick_part());
				end
				send_parts(q, 1'b1);
			end
			// Leave a composition open across the next modulus write
			if ($urandom_range(4) == 0) begin
				q.delete();
				repeat ($urandom_range(1, 3)) q.push_back(pick_part());
				send_parts(q, 1'b0);
			end
			phase++;
		end
		settle();

		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
